@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms used by lcm_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked while reset is released
`define ASSERT_CLKRST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/lcm_pkg.sv @@
// ----------------------------------------------------------------------------
// lcm_pkg
// types, constants and helpers of the line continuation measurer
// ----------------------------------------------------------------------------
package lcm_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CHAR_WIDTH  = 8;
    localparam int RES_BITS    = 2 * COUNT_WIDTH;
    localparam int OUT_TDATA_W = ((RES_BITS + 7) / 8) * 8;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [CHAR_WIDTH-1:0]  char_t;

    localparam count_t COUNT_MAX = '1;
    localparam count_t COUNT_ONE = count_t'(1);

    localparam char_t CH_BSLASH = 8'h5C;
    localparam char_t CH_LF     = 8'h0A;
    localparam char_t CH_CR     = 8'h0D;
    localparam char_t CH_SP     = 8'h20;
    localparam char_t CH_TAB    = 8'h09;
    localparam char_t CH_FF     = 8'h0C;
    localparam char_t CH_VT     = 8'h0B;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_START    = 5'b00010,
        PH_BLANKS   = 5'b00100,
        PH_AFTER_LF = 5'b01000,
        PH_AFTER_CR = 5'b10000
    } phase_t;

    typedef struct packed {
        char_t char_in;
        logic  begin_run;
    } item_t;

    typedef struct packed {
        count_t line_count;
        count_t run_length;
    } result_t;

    function automatic count_t sat_add(count_t a, count_t b);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_WIDTH] ? COUNT_MAX : s[COUNT_WIDTH-1:0];
    endfunction

    function automatic logic is_blank(char_t c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_FF) || (c == CH_VT);
    endfunction

endpackage

@@ hw/rtl/lcm_in_stage.sv @@
// ----------------------------------------------------------------------------
// lcm_in_stage
// input register holding one accepted byte until the scanner takes it
// ----------------------------------------------------------------------------
module lcm_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  lcm_pkg::item_t s_item,
    input  logic           take_ok,
    output logic           item_valid,
    output lcm_pkg::item_t item
);
    import lcm_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready = !valid_reg || take_ok;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (valid_reg && take_ok) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ hw/rtl/lcm_scan.sv @@
// ----------------------------------------------------------------------------
// lcm_scan
// continuation state machine with saturating byte and line counters
// ----------------------------------------------------------------------------
module lcm_scan (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  lcm_pkg::item_t   item,
    output logic             res_valid,
    output lcm_pkg::result_t result
);
    import lcm_pkg::*;

    phase_t phase_reg,   phase_next;
    count_t clen_reg,    clen_next;
    count_t plen_reg,    plen_next;
    count_t clines_reg,  clines_next;
    phase_t ph;
    count_t clen_in;
    count_t plen_in;
    count_t clines_in;
    logic   ends;
    char_t  c;

    assign c = item.char_in;

    always_comb begin
        ph        = item.begin_run ? PH_START : phase_reg;
        clen_in   = item.begin_run ? '0 : clen_reg;
        plen_in   = item.begin_run ? '0 : plen_reg;
        clines_in = item.begin_run ? '0 : clines_reg;

        phase_next  = ph;
        clen_next   = clen_in;
        plen_next   = plen_in;
        clines_next = clines_in;
        ends        = 1'b0;

        unique case (ph)
            PH_START: begin
                if (c == CH_BSLASH) begin
                    plen_next  = COUNT_ONE;
                    phase_next = PH_BLANKS;
                end else begin
                    ends = 1'b1;
                end
            end
            PH_BLANKS: begin
                if (is_blank(c)) begin
                    plen_next = sat_add(plen_in, COUNT_ONE);
                end else if (c == CH_LF || c == CH_CR) begin
                    clen_next   = sat_add(clen_in, sat_add(plen_in, COUNT_ONE));
                    clines_next = sat_add(clines_in, COUNT_ONE);
                    plen_next   = '0;
                    phase_next  = (c == CH_LF) ? PH_AFTER_LF : PH_AFTER_CR;
                end else begin
                    ends = 1'b1;
                end
            end
            PH_AFTER_LF, PH_AFTER_CR: begin
                if ((ph == PH_AFTER_LF && c == CH_CR) ||
                    (ph == PH_AFTER_CR && c == CH_LF)) begin
                    clen_next = sat_add(clen_in, sat_add(plen_in, COUNT_ONE));
                    if (ph == PH_AFTER_LF) begin
                        clines_next = sat_add(clines_in, COUNT_ONE);
                    end
                    plen_next  = '0;
                    phase_next = PH_START;
                end else if (c == CH_BSLASH) begin
                    plen_next  = COUNT_ONE;
                    phase_next = PH_BLANKS;
                end else begin
                    ends = 1'b1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        result.run_length = clen_next;
        result.line_count = clines_next;

        if (ends) begin
            phase_next  = PH_IDLE;
            clen_next   = '0;
            plen_next   = '0;
            clines_next = '0;
        end
    end

    assign res_valid = fire && ends;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            clen_reg   <= '0;
            plen_reg   <= '0;
            clines_reg <= '0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            clen_reg   <= clen_next;
            plen_reg   <= plen_next;
            clines_reg <= clines_next;
        end
    end

endmodule

@@ hw/rtl/lcm_out_stage.sv @@
// ----------------------------------------------------------------------------
// lcm_out_stage
// result register on the master side of the stream
// ----------------------------------------------------------------------------
module lcm_out_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             res_valid,
    input  lcm_pkg::result_t                 result,
    output logic                             out_free,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lcm_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import lcm_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (out_free) begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_valid) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = OUT_TDATA_W'(result_reg);

endmodule

@@ hw/rtl/line_continuation_measurer.sv @@
// ----------------------------------------------------------------------------
// line_continuation_measurer
// measures runs of backslash line continuations in a byte stream
// ----------------------------------------------------------------------------
// result path: the ending byte is held in lcm_in_stage, and its result is registered in lcm_out_stage for m_tvalid
// throughput: one byte per cycle while the result register is empty or m_tready is high
// reset: synchronous active-low aresetn returns the scanner to idle with zero counts
// and empties the input and result registers
// ----------------------------------------------------------------------------
module line_continuation_measurer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lcm_pkg::CHAR_WIDTH-1:0]   s_tdata,  // char_in
    input  logic                             s_tuser,  // begin_run
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lcm_pkg::OUT_TDATA_W-1:0]  m_tdata   // run_length, line_count
);
    import lcm_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    out_free;
    logic    fire;
    logic    res_valid;
    result_t result;

    assign s_item.char_in   = s_tdata;
    assign s_item.begin_run = s_tuser;
    assign fire             = item_valid && out_free;

    lcm_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take_ok    (out_free),
        .item_valid (item_valid),
        .item       (item)
    );

    lcm_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .result    (result)
    );

    lcm_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .result    (result),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ hw/rtl/lcm_checker.sv @@
// ----------------------------------------------------------------------------
// lcm_checker
// port-level assertions for the line continuation measurer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcm_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [lcm_pkg::CHAR_WIDTH-1:0]   s_tdata,
    input logic                             s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [lcm_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import lcm_pkg::*;

    logic   [CHAR_WIDTH-1:0] unused_char;
    logic                    unused_user;
    logic                    unused_valid;
    count_t                  run_len;
    count_t                  lines;

    assign unused_char  = s_tdata;
    assign unused_user  = s_tuser;
    assign unused_valid = s_tvalid;
    assign run_len      = m_tdata[COUNT_WIDTH-1:0];
    assign lines        = m_tdata[RES_BITS-1:COUNT_WIDTH];

    `ASSERT_CLK(a_reset_clears_out, aclk, $past(!aresetn) |-> !m_tvalid, "result valid after reset")
    `ASSERT_CLKRST(a_out_stall_holds, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")
    `ASSERT_CLKRST(a_lines_le_len, aclk, aresetn, m_tvalid |-> (lines <= run_len), "more lines than bytes")
    `ASSERT_CLKRST(a_ready_when_empty, aclk, aresetn, !m_tvalid |-> s_tready, "input stalled with empty output")

endmodule

bind line_continuation_measurer lcm_checker u_lcm_checker (.*);

@@ tb/lcm_splice_checker.sv @@
// ----------------------------------------------------------------------------
// lcm_splice_checker
// watches both stream channels of the line continuation measurer, keeps its
// own model of the splice scanner, and compares every result transfer with
// the oldest expected run length and line count
// ----------------------------------------------------------------------------
module lcm_splice_checker
    import lcm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [CHAR_WIDTH-1:0]  s_tdata,   // char_in
    input  logic                   s_tuser,   // begin_run
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // run_length, line_count
    output int                     failures,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    phase_t  scan_phase;
    count_t  done_bytes;
    count_t  open_bytes;
    count_t  done_lines;
    result_t expected_counts[$];
    int      error_tally;

    function automatic count_t add_clamped(count_t a, count_t b);
        logic [COUNT_WIDTH:0] total;
        total = {1'b0, a} + {1'b0, b};
        if (total[COUNT_WIDTH]) begin
            return COUNT_MAX;
        end
        return total[COUNT_WIDTH-1:0];
    endfunction

    function automatic logic blank_char(char_t c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_FF) || (c == CH_VT);
    endfunction

    task automatic close_splice(count_t extra, count_t lines);
        done_bytes = add_clamped(done_bytes, add_clamped(open_bytes, extra));
        done_lines = add_clamped(done_lines, lines);
        open_bytes = '0;
    endtask

    task automatic clear_run();
        scan_phase = PH_IDLE;
        done_bytes = '0;
        open_bytes = '0;
        done_lines = '0;
    endtask

    task automatic measure_char(char_t c, logic first);
        logic    run_over;
        result_t counts;
        run_over = 1'b0;
        if (first) begin
            clear_run();
            scan_phase = PH_START;
        end
        case (scan_phase)
            PH_START: begin
                if (c == CH_BSLASH) begin
                    open_bytes = COUNT_ONE;
                    scan_phase = PH_BLANKS;
                end else begin
                    run_over = 1'b1;
                end
            end
            PH_BLANKS: begin
                if (blank_char(c)) begin
                    open_bytes = add_clamped(open_bytes, COUNT_ONE);
                end else if (c == CH_LF) begin
                    close_splice(COUNT_ONE, COUNT_ONE);
                    scan_phase = PH_AFTER_LF;
                end else if (c == CH_CR) begin
                    close_splice(COUNT_ONE, COUNT_ONE);
                    scan_phase = PH_AFTER_CR;
                end else begin
                    run_over = 1'b1;
                end
            end
            PH_AFTER_LF, PH_AFTER_CR: begin
                if (scan_phase == PH_AFTER_LF && c == CH_CR) begin
                    // lf cr crosses a second line
                    close_splice(COUNT_ONE, COUNT_ONE);
                    scan_phase = PH_START;
                end else if (scan_phase == PH_AFTER_CR && c == CH_LF) begin
                    close_splice(COUNT_ONE, '0);
                    scan_phase = PH_START;
                end else if (c == CH_BSLASH) begin
                    open_bytes = COUNT_ONE;
                    scan_phase = PH_BLANKS;
                end else begin
                    run_over = 1'b1;
                end
            end
            default: begin
                scan_phase = PH_IDLE;
            end
        endcase
        if (run_over) begin
            counts.run_length = done_bytes;
            counts.line_count = done_lines;
            expected_counts.push_back(counts);
            clear_run();
        end
    endtask

    task automatic check_result(result_t got);
        result_t want;
        if (expected_counts.size() == 0) begin
            $display("%0t: unexpected result transfer, run_length %0d line_count %0d",
                     $time, got.run_length, got.line_count);
            error_tally++;
        end else begin
            want = expected_counts.pop_front();
            if (got.run_length !== want.run_length) begin
                $display("%0t: run_length mismatch, expected %0d actual %0d",
                         $time, want.run_length, got.run_length);
                error_tally++;
            end
            if (got.line_count !== want.line_count) begin
                $display("%0t: line_count mismatch, expected %0d actual %0d",
                         $time, want.line_count, got.line_count);
                error_tally++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_run();
            expected_counts.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata[RES_BITS-1:0]);
            end
            if (s_tvalid && s_tready) begin
                measure_char(s_tdata, s_tuser);
            end
        end
        failures <= error_tally;
        outstanding <= expected_counts.size();
    end

endmodule

@@ tb/line_continuation_measurer_tb.sv @@
// ----------------------------------------------------------------------------
// line_continuation_measurer_tb
// drives directed splice sequences and random runs of continuations
// through the measurer under several sender and receiver idle mixes;
// a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module line_continuation_measurer_tb;
    import lcm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [CHAR_WIDTH-1:0]  s_tdata = '0;    // char_in
    logic                   s_tuser = 1'b0;  // begin_run
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // run_length, line_count

    int failures;
    int outstanding;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    char_t blank_set[4] = '{CH_SP, CH_TAB, CH_FF, CH_VT};

    always #6 aclk = ~aclk;

    line_continuation_measurer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lcm_splice_checker splice_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_char(char_t c, logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tuser <= first;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_line_break();
        case ($urandom_range(3))
            0: send_char(CH_LF, 1'b0);
            1: send_char(CH_CR, 1'b0);
            2: begin
                send_char(CH_CR, 1'b0);
                send_char(CH_LF, 1'b0);
            end
            default: begin
                send_char(CH_LF, 1'b0);
                send_char(CH_CR, 1'b0);
            end
        endcase
    endtask

    task automatic send_blanks(int most);
        repeat ($urandom_range(most)) send_char(blank_set[$urandom_range(3)], 1'b0);
    endtask

    task automatic send_splice_run();
        int splices;
        if ($urandom_range(9) == 0) begin
            // noise with random run starts
            repeat ($urandom_range(1, 6)) begin
                send_char(char_t'($urandom_range(255)), ($urandom_range(3) == 0));
            end
            return;
        end
        splices = $urandom_range(0, 6);
        if ($urandom_range(9) == 0) begin
            send_char(char_t'($urandom_range(255)), 1'b1);
        end else begin
            send_char(CH_BSLASH, 1'b1);
        end
        for (int i = 0; i < splices; i++) begin
            send_blanks(3);
            send_line_break();
            if (i < splices - 1) begin
                send_char(CH_BSLASH, 1'b0);
            end
        end
        case ($urandom_range(3))
            0: send_char(char_t'($urandom_range(255)), 1'b0);
            1: begin
                // dangling backslash
                send_char(CH_BSLASH, 1'b0);
                send_blanks(2);
                send_char(char_t'($urandom_range(255)), 1'b0);
            end
            2: ;  // next run restarts this one
            default: begin
                send_char(char_t'($urandom_range(255)), 1'b0);
                repeat ($urandom_range(2)) send_char(char_t'($urandom_range(255)), 1'b0);
            end
        endcase
    endtask

    task automatic random_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_splice_run();
        // zero ends any open run and is dropped when idle
        send_char(8'h00, 1'b0);
    endtask

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        send_char("a", 1'b0);
        send_char("x", 1'b1);
        send_char(CH_BSLASH, 1'b1);
        send_char(CH_LF, 1'b0);
        send_char(CH_BSLASH, 1'b0);
        send_char(CH_SP, 1'b0);
        send_char(CH_TAB, 1'b0);
        send_char(CH_FF, 1'b0);
        send_char(CH_VT, 1'b0);
        send_char(CH_CR, 1'b0);
        send_char(CH_LF, 1'b0);
        send_char(CH_BSLASH, 1'b0);
        send_char(CH_LF, 1'b0);
        send_char(CH_CR, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(CH_BSLASH, 1'b1);
        send_char(CH_BSLASH, 1'b1);
        send_char(CH_LF, 1'b0);
        send_char("q", 1'b0);
        send_char(CH_BSLASH, 1'b1);
        send_char(CH_SP, 1'b0);
        send_char("z", 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);

        random_phase(0, 0, 20);
        random_phase(64, 0, 20);
        random_phase(0, 64, 20);
        random_phase(24, 24, 20);
        random_phase(0, 0, 10);
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (outstanding != 0);
        repeat (20) @(posedge aclk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
